// ----- hdl/assert_macros.svh -----
// assertion macros used by the ring pointer manager rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define SQCQ_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sqcq assertion failed");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define SQCQ_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sqcq assertion failed");

`endif

// ----- hdl/sqcq_pkg.sv -----
// constants, item types and control types of the ring pointer manager
package sqcq_pkg;

  localparam int unsigned SQ_DEPTH = 1024;
  localparam int unsigned CQ_DEPTH = 1024;
  localparam int unsigned NUM_SQ   = 16;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned ID_W     = 4;
  localparam int unsigned HEAD_W   = 16;
  localparam int unsigned REQ_W    = 11;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned TAKEN_W  = 11;
  localparam int unsigned BELL_W   = 10;
  localparam int unsigned PEND_W   = 16;

  localparam int unsigned SQ_PTR_W = $clog2(SQ_DEPTH);
  localparam int unsigned CQ_PTR_W = $clog2(CQ_DEPTH);
  localparam int unsigned CQ_CNT_W = CQ_PTR_W + 1;
  localparam int unsigned SQ_IDX_W = (NUM_SQ > 1) ? $clog2(NUM_SQ) : 1;
  localparam int unsigned REQ_CMP_W  = (REQ_W > CQ_CNT_W) ? REQ_W : CQ_CNT_W;
  localparam int unsigned PEND_CMP_W = (PEND_W > CQ_CNT_W) ? PEND_W : CQ_CNT_W;
  localparam int unsigned RHEAD_CMP_W = (HEAD_W > SQ_PTR_W) ? HEAD_W + 1 : SQ_PTR_W + 1;

  localparam logic [SQ_PTR_W-1:0] SQ_LAST = SQ_PTR_W'(SQ_DEPTH - 1);
  localparam logic [CQ_PTR_W-1:0] CQ_LAST = CQ_PTR_W'(CQ_DEPTH - 1);

  typedef enum logic [OP_W-1:0] {
    OP_SUBMIT = 2'd0,
    OP_REPORT = 2'd1,
    OP_FETCH  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_NO_CREDIT    = 3'd1,
    ST_WRAP_BLOCKED = 3'd2,
    ST_EMPTY        = 3'd3,
    ST_CQ_FULL      = 3'd4,
    ST_BAD_HEAD     = 3'd5
  } status_e;

  typedef struct packed {
    op_e               operation;
    logic [ID_W-1:0]   sq_id;
    logic              entry_phase;
    logic [HEAD_W-1:0] reported_sq_head;
    logic [REQ_W-1:0]  request_count;
  } in_item_t;

  typedef struct packed {
    status_e            status;
    logic [TAKEN_W-1:0] taken_count;
    logic [BELL_W-1:0]  doorbell_value;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic execute;
  } cmd_t;

endpackage

// ----- hdl/sq_cq_ring_pointer_manager.sv -----
// top level of the submission and completion ring pointer manager
// an accepted item is captured, then executed into the result register once the
// output register is free; the input stalls until the previous item has executed
// a new item is taken while the previous result still waits in the output register
// reset: asynchronous, all ring pointers, credits and the pending count go to zero
// and the completion valid phase goes to one; no clearing pass is needed
`include "assert_macros.svh"

module sq_cq_ring_pointer_manager (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sqcq_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sqcq_pkg::out_item_t out_item_o
);
  import sqcq_pkg::*;

  // capture and execute strobes from the controller
  cmd_t cmd;

  // controller: idle waits for an item, exec fires once the output register
  // is free, so a stalled result is never overwritten
  sqcq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // datapath: per-ring head, tail and credit tables, completion ring head,
  // tail and phase, pending report count, and the registered result
  sqcq_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_item_i  (in_item_i),
    .out_item_o (out_item_o)
  );

  // execution must never land on a result that is still held by the consumer
  `SQCQ_ASSERT_IMP(a_no_overwrite, cmd.execute, !(out_valid_o && out_stall_i))
  // an accepted item keeps the input side busy in the next cycle
  `SQCQ_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  // a new result appears only right after an execute
  `SQCQ_ASSERT_IMP(a_valid_from_exec, $rose(out_valid_o), $past(cmd.execute))

endmodule

// ----- hdl/sqcq_ctrl.sv -----
// handshake controller: sequences capture and execution of one item
module sqcq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output sqcq_pkg::cmd_t   cmd_o
);
  import sqcq_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  // the output register is free when empty or being drained this cycle
  assign out_free        = !out_valid_q || !out_stall_i;
  assign in_stall_o      = (state_q != S_IDLE);
  assign cmd_o.load_item = in_valid_i && (state_q == S_IDLE);
  assign cmd_o.execute   = (state_q == S_EXEC) && out_free;
  assign out_valid_o     = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (cmd_o.load_item) state_q <= S_EXEC;
        end
        S_EXEC: begin
          if (cmd_o.execute) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
      if (cmd_o.execute) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ----- hdl/sqcq_dp.sv -----
// datapath: ring pointer tables, completion ring state and result register
module sqcq_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sqcq_pkg::cmd_t      cmd_i,
  input  sqcq_pkg::in_item_t  in_item_i,
  output sqcq_pkg::out_item_t out_item_o
);
  import sqcq_pkg::*;

  in_item_t  item_q;
  out_item_t result_q;
  out_item_t result_d;

  logic [SQ_PTR_W-1:0] sq_head_q   [NUM_SQ];
  logic [SQ_PTR_W-1:0] sq_tail_q   [NUM_SQ];
  logic [SQ_PTR_W-1:0] sq_credit_q [NUM_SQ];

  logic [CQ_PTR_W-1:0] cq_head_q, cq_head_d;
  logic [CQ_PTR_W-1:0] cq_tail_q, cq_tail_d;
  logic                cq_phase_q, cq_phase_d;
  logic [PEND_W-1:0]   pending_q, pending_d;

  logic                head_we, tail_we, credit_we;
  logic [SQ_PTR_W-1:0] head_wdata, tail_wdata, credit_wdata;

  logic [SQ_IDX_W-1:0] idx;
  logic                id_ok;
  logic [SQ_PTR_W-1:0] h, t, c;
  logic [SQ_PTR_W:0]   credit_calc;
  logic [SQ_PTR_W-1:0] credit_eff;
  logic                wrap_blk;
  logic [SQ_PTR_W-1:0] t_next;
  logic                rhead_ok;
  logic [CQ_PTR_W-1:0] cq_tail_next;
  logic [CQ_CNT_W-1:0] avail, take_n, head_sum;
  logic [CQ_PTR_W-1:0] cq_head_new;
  logic [PEND_W-1:0]   pending_sub;

  assign idx   = SQ_IDX_W'(item_q.sq_id);
  assign id_ok = (32'(item_q.sq_id) < NUM_SQ);
  assign h     = sq_head_q[idx];
  assign t     = sq_tail_q[idx];
  assign c     = sq_credit_q[idx];

  // credit from head and tail, one slot kept free
  always_comb begin
    if (t >= h) begin
      credit_calc = (SQ_PTR_W+1)'(SQ_DEPTH) - ({1'b0, t} - {1'b0, h} + 1'b1);
    end else begin
      credit_calc = {1'b0, h} - {1'b0, t} - 1'b1;
    end
  end

  assign credit_eff = (c == '0) ? SQ_PTR_W'(credit_calc) : c;
  assign wrap_blk   = (t >= h) && (t == SQ_LAST) && (h == '0);
  assign t_next     = (t == SQ_LAST) ? '0 : t + 1'b1;
  assign rhead_ok   = (RHEAD_CMP_W'(item_q.reported_sq_head) < RHEAD_CMP_W'(SQ_DEPTH));

  assign cq_tail_next = (cq_tail_q == CQ_LAST) ? '0 : cq_tail_q + 1'b1;

  // contiguous entries up to the tail or the end of the ring
  assign avail = (cq_tail_q > cq_head_q) ? ({1'b0, cq_tail_q} - {1'b0, cq_head_q})
                                         : (CQ_CNT_W'(CQ_DEPTH) - {1'b0, cq_head_q});
  assign take_n = (REQ_CMP_W'(item_q.request_count) < REQ_CMP_W'(avail))
                  ? CQ_CNT_W'(item_q.request_count) : avail;
  assign head_sum    = {1'b0, cq_head_q} + take_n;
  assign cq_head_new = (head_sum == CQ_CNT_W'(CQ_DEPTH)) ? '0 : CQ_PTR_W'(head_sum);
  // saturate at zero
  assign pending_sub = (PEND_CMP_W'(pending_q) > PEND_CMP_W'(take_n))
                       ? PEND_W'(PEND_CMP_W'(pending_q) - PEND_CMP_W'(take_n)) : '0;

  always_comb begin
    result_d     = '0;
    head_we      = 1'b0;
    tail_we      = 1'b0;
    credit_we    = 1'b0;
    head_wdata   = SQ_PTR_W'(item_q.reported_sq_head);
    tail_wdata   = t_next;
    credit_wdata = credit_eff;
    cq_head_d    = cq_head_q;
    cq_tail_d    = cq_tail_q;
    cq_phase_d   = cq_phase_q;
    pending_d    = pending_q;
    case (item_q.operation)
      OP_SUBMIT: begin
        if (!id_ok) begin
          result_d.status = ST_NO_CREDIT;
        end else begin
          // recomputed credit is kept even when the submit fails for lack of credit or a blocked wrap
          credit_we = (c == '0);
          if (credit_eff == '0) begin
            result_d.status = ST_NO_CREDIT;
          end else if (wrap_blk) begin
            result_d.status = ST_WRAP_BLOCKED;
          end else begin
            credit_we               = 1'b1;
            credit_wdata            = credit_eff - 1'b1;
            tail_we                 = 1'b1;
            pending_d               = pending_q + 1'b1;
            result_d.status         = ST_OK;
            result_d.doorbell_value = BELL_W'(t_next);
          end
        end
      end
      OP_REPORT: begin
        if (item_q.entry_phase != cq_phase_q) begin
          result_d.status = ST_EMPTY;
        end else if (cq_tail_next == cq_head_q) begin
          result_d.status = ST_CQ_FULL;
        end else if (!id_ok || !rhead_ok) begin
          result_d.status = ST_BAD_HEAD;
        end else begin
          head_we   = 1'b1;
          cq_tail_d = cq_tail_next;
          if (cq_tail_q == CQ_LAST) cq_phase_d = !cq_phase_q;
          result_d.status = ST_OK;
        end
      end
      OP_FETCH: begin
        if (cq_head_q == cq_tail_q) begin
          result_d.status = ST_EMPTY;
        end else begin
          cq_head_d               = cq_head_new;
          pending_d               = pending_sub;
          result_d.status         = ST_OK;
          result_d.taken_count    = TAKEN_W'(take_n);
          result_d.doorbell_value = BELL_W'(cq_head_new);
        end
      end
      default: result_d = '0;
    endcase
  end

  // item and result registers carry payload only
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) item_q <= in_item_i;
    if (cmd_i.execute) result_q <= result_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SQ; i++) begin
        sq_head_q[i]   <= '0;
        sq_tail_q[i]   <= '0;
        sq_credit_q[i] <= '0;
      end
      cq_head_q  <= '0;
      cq_tail_q  <= '0;
      cq_phase_q <= 1'b1;
      pending_q  <= '0;
    end else if (cmd_i.execute) begin
      if (head_we) sq_head_q[idx] <= head_wdata;
      if (tail_we) sq_tail_q[idx] <= tail_wdata;
      if (credit_we) sq_credit_q[idx] <= credit_wdata;
      cq_head_q  <= cq_head_d;
      cq_tail_q  <= cq_tail_d;
      cq_phase_q <= cq_phase_d;
      pending_q  <= pending_d;
    end
  end

  assign out_item_o = result_q;

endmodule
